// ----- rtl/rfc_pkg.sv -----
package rfc_pkg;

  // Width of the request index as it arrives on the input channel
  localparam int INDEX_BITS = 16;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DISABLED = 2'd1;
  localparam logic [1:0] STAT_PRE_HIT  = 2'd2;
  localparam logic [1:0] STAT_NO_SLOT  = 2'd3;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ENABLE      = 2'd0;
  localparam logic [1:0] REG_MAX_ENTRIES = 2'd1;
  localparam logic [1:0] REG_MAX_BYTES   = 2'd2;
  localparam logic [1:0] REG_THRESHOLD   = 2'd3;

  // Highest reference count an entry can hold
  localparam logic [1:0] REF_LIMIT = 2'd3;

  localparam logic [30:0] BYTE_MAX = 31'h7FFF_FFFF;
  localparam logic [10:0] CNT_MAX  = 11'h7FF;

  typedef struct packed {
    logic        enable;
    logic [10:0] max_entries;
    logic [29:0] max_bytes;
    logic [11:0] threshold;
  } rfc_cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        was_present;
    logic [10:0] freed_count;
    logic [1:0]  entry_refcount;
    logic [10:0] cached_count;
    logic [30:0] cached_bytes;
  } rfc_result_t;

  // Subtract a length from the byte total, floor at zero
  function automatic logic [30:0] bytes_sub(logic [30:0] total, logic [31:0] n);
    logic [32:0] t;
    logic [32:0] m;
    t = {2'b00, total};
    m = {1'b0, n};
    bytes_sub = (t >= m) ? 31'(t - m) : 31'd0;
  endfunction

  // Add a length to the byte total, saturate at the top
  function automatic logic [30:0] bytes_add(logic [30:0] total, logic [31:0] n);
    logic [32:0] s;
    s = {2'b00, total} + {1'b0, n};
    bytes_add = (s > {2'b00, BYTE_MAX}) ? BYTE_MAX : 31'(s);
  endfunction

endpackage

// ----- rtl/rfc_ram.sv -----
module rfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rfc_front.sv -----
module rfc_front import rfc_pkg::*; #(
  parameter int NODE_COUNT  = 65536,
  parameter int LENGTH_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          hold,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [INDEX_BITS-1:0]         in_block_index,
  input  logic [LENGTH_BITS-1:0]        in_value_length,
  input  logic                          in_rewrite,
  input  logic                          in_preread,
  output logic                          req_valid,
  input  logic                          req_pop,
  output logic [$clog2(NODE_COUNT)-1:0] req_idx,
  output logic [LENGTH_BITS-1:0]        req_len,
  output logic                          req_rewrite,
  output logic                          req_preread
);

  localparam int IDX_W   = $clog2(NODE_COUNT);
  localparam int SHIFT   = INDEX_BITS + IDX_W;
  localparam int RECIP_W = 18;
  localparam int PROD_W  = INDEX_BITS + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(NODE_COUNT) - 64'd1) / 64'(NODE_COUNT);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int FDEPTH = 4;

  // Stage 1: index times reciprocal
  logic                   s1_v_r;
  logic [INDEX_BITS-1:0]  s1_x_r;
  logic [PROD_W-1:0]      s1_prod_r;
  logic [LENGTH_BITS-1:0] s1_len_r;
  logic                   s1_rw_r;
  logic                   s1_pr_r;

  // Stage 2: quotient times node count
  logic                   s2_v_r;
  logic [INDEX_BITS-1:0]  s2_x_r;
  logic [INDEX_BITS-1:0]  s2_qn_r;
  logic [LENGTH_BITS-1:0] s2_len_r;
  logic                   s2_rw_r;
  logic                   s2_pr_r;

  logic [INDEX_BITS-1:0]  s1_q;
  logic [INDEX_BITS-1:0]  s2_qn_nxt;
  logic [IDX_W-1:0]       s2_rem;

  // Request queue toward the back end
  logic [IDX_W-1:0]       f_idx_r [FDEPTH];
  logic [LENGTH_BITS-1:0] f_len_r [FDEPTH];
  logic [FDEPTH-1:0]      f_rw_r;
  logic [FDEPTH-1:0]      f_pr_r;
  logic [1:0]             wptr_r;
  logic [1:0]             rptr_r;
  logic [2:0]             fcnt_r;
  logic [3:0]             inflight;
  logic                   accept;

  assign inflight = 4'(fcnt_r) + 4'(s1_v_r) + 4'(s2_v_r);
  assign in_full  = hold || (inflight >= 4'(FDEPTH));
  assign accept   = in_push && !in_full;

  assign s1_q      = INDEX_BITS'(s1_prod_r >> SHIFT);
  assign s2_qn_nxt = INDEX_BITS'(32'(s1_q) * 32'(NODE_COUNT));
  assign s2_rem    = IDX_W'(s2_x_r - s2_qn_r);

  // Advance valid bits and queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      wptr_r <= '0;
      rptr_r <= '0;
      fcnt_r <= '0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      if (s2_v_r) begin
        wptr_r <= wptr_r + 2'd1;
      end
      if (req_pop) begin
        rptr_r <= rptr_r + 2'd1;
      end
      fcnt_r <= fcnt_r + 3'(s2_v_r) - 3'(req_pop);
    end
  end

  // Carry payload through the reduction stages into the queue
  always_ff @(posedge clk) begin
    s1_x_r    <= in_block_index;
    s1_prod_r <= PROD_W'(in_block_index) * PROD_W'(RECIP);
    s1_len_r  <= in_value_length;
    s1_rw_r   <= in_rewrite;
    s1_pr_r   <= in_preread;
    s2_x_r    <= s1_x_r;
    s2_qn_r   <= s2_qn_nxt;
    s2_len_r  <= s1_len_r;
    s2_rw_r   <= s1_rw_r;
    s2_pr_r   <= s1_pr_r;
    if (s2_v_r) begin
      f_idx_r[wptr_r] <= s2_rem;
      f_len_r[wptr_r] <= s2_len_r;
      f_rw_r[wptr_r]  <= s2_rw_r;
      f_pr_r[wptr_r]  <= s2_pr_r;
    end
  end

  assign req_valid   = (fcnt_r != 3'd0);
  assign req_idx     = f_idx_r[rptr_r];
  assign req_len     = f_len_r[rptr_r];
  assign req_rewrite = f_rw_r[rptr_r];
  assign req_preread = f_pr_r[rptr_r];

  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= 3'(FDEPTH))
    else $error("request queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (fcnt_r != 3'(FDEPTH)) || req_pop)
    else $error("request queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    req_pop |-> fcnt_r != 3'd0)
    else $error("request queue popped while empty");

endmodule

// ----- rtl/rfc_back.sv -----
module rfc_back import rfc_pkg::*; #(
  parameter int NODE_COUNT  = 65536,
  parameter int SLOT_COUNT  = 1024,
  parameter int QUEUE_DEPTH = 4096,
  parameter int LENGTH_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rfc_cfg_t                      cfg,
  input  logic                          req_valid,
  output logic                          req_pop,
  input  logic [$clog2(NODE_COUNT)-1:0] req_idx,
  input  logic [LENGTH_BITS-1:0]        req_len,
  input  logic                          req_rewrite,
  input  logic                          req_preread,
  output logic                          clearing,
  output logic                          res_valid,
  output rfc_result_t                   res,
  input  logic                          res_pop
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int LB    = LENGTH_BITS;
  localparam int EW    = LB + 3;
  localparam int TOT_W = $clog2(SLOT_COUNT + 1);
  localparam int CW    = (TOT_W > 12) ? TOT_W : 12;
  localparam int QAW   = $clog2(QUEUE_DEPTH);
  localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = (QCW > 12) ? QCW : 12;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WAS, S_EVCHK, S_EVQ, S_EVM, S_TDEC, S_TAPPLY, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [LB-1:0]    len_r, len_nxt;
  logic             rw_r, rw_nxt;
  logic             pr_r, pr_nxt;
  logic [IDX_W-1:0] vic_r, vic_nxt;
  logic             src_r, src_nxt;
  logic             was_r, was_nxt;
  logic [10:0]      freed_r, freed_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [1:0]       refout_r, refout_nxt;
  logic [1:0]       cur_refs_r, cur_refs_nxt;
  logic [LB-1:0]    oldlen_r, oldlen_nxt;
  logic             rweff_r, rweff_nxt;
  logic [TOT_W-1:0] tot_r, tot_nxt;
  logic [30:0]      bytes_r, bytes_nxt;
  logic [QAW-1:0]   ahead_r, ahead_nxt, atail_r, atail_nxt;
  logic [QAW-1:0]   phead_r, phead_nxt, ptail_r, ptail_nxt;
  logic [QCW-1:0]   acnt_r, acnt_nxt, pcnt_r, pcnt_nxt;
  logic             out_v_r, out_v_nxt;
  rfc_result_t      res_r, res_nxt;

  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0]    ent_wdata, ent_rdata;
  logic             ent_p;
  logic [1:0]       ent_refs;
  logic [LB-1:0]    ent_len;
  logic             qa_we, qp_we;
  logic [IDX_W-1:0] qa_rdata, qp_rdata;

  logic             need_evict;
  logic             do_push;
  logic [QCW-1:0]   tgt_cnt;
  logic [1:0]       refs_new;
  logic [LB-1:0]    newlen;
  logic [IDX_W-1:0] victim;
  logic [10:0]      count_out;

  assign ent_p    = ent_rdata[EW-1];
  assign ent_refs = ent_rdata[LB+1:LB];
  assign ent_len  = ent_rdata[LB-1:0];

  assign need_evict = (CW'(tot_r) >= CW'(cfg.max_entries)) ||
                      (bytes_r >= 31'(cfg.max_bytes));
  assign tgt_cnt    = pr_r ? pcnt_r : acnt_r;
  assign do_push    = (cur_refs_r != REF_LIMIT) && (tgt_cnt < QCW'(QUEUE_DEPTH));
  assign refs_new   = cur_refs_r + 2'(do_push);
  assign newlen     = rweff_r ? len_r : oldlen_r;
  assign victim     = src_r ? qp_rdata : qa_rdata;
  assign count_out  = (CW'(tot_r) > CW'(CNT_MAX)) ? CNT_MAX : 11'(tot_r);

  // Per-request sequencer after the clearing pass: evict, then touch; a disabled cache skips both
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    rw_nxt       = rw_r;
    pr_nxt       = pr_r;
    vic_nxt      = vic_r;
    src_nxt      = src_r;
    was_nxt      = was_r;
    freed_nxt    = freed_r;
    status_nxt   = status_r;
    refout_nxt   = refout_r;
    cur_refs_nxt = cur_refs_r;
    oldlen_nxt   = oldlen_r;
    rweff_nxt    = rweff_r;
    tot_nxt      = tot_r;
    bytes_nxt    = bytes_r;
    ahead_nxt    = ahead_r;
    atail_nxt    = atail_r;
    phead_nxt    = phead_r;
    ptail_nxt    = ptail_r;
    acnt_nxt     = acnt_r;
    pcnt_nxt     = pcnt_r;
    out_v_nxt    = out_v_r;
    res_nxt      = res_r;
    req_pop      = 1'b0;
    ent_we       = 1'b0;
    ent_waddr    = idx_r;
    ent_wdata    = '0;
    ent_raddr    = idx_r;
    qa_we        = 1'b0;
    qp_we        = 1'b0;

    // Drop the result beat once taken
    if (out_v_r && res_pop) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_r;
        if (clr_r == IDX_W'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        ent_raddr = req_idx;
        if (req_valid) begin
          req_pop   = 1'b1;
          idx_nxt   = req_idx;
          len_nxt   = req_len;
          rw_nxt    = req_rewrite;
          pr_nxt    = req_preread;
          state_nxt = S_WAS;
        end
      end
      S_WAS: begin
        was_nxt   = ent_p;
        freed_nxt = '0;
        if (!cfg.enable) begin
          status_nxt = STAT_DISABLED;
          refout_nxt = ent_p ? ent_refs : 2'd0;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_EVCHK;
        end
      end
      S_EVCHK: begin
        state_nxt = S_TDEC;
        if (need_evict) begin
          if (TW'(pcnt_r) > TW'(cfg.threshold) || (acnt_r == '0 && pcnt_r != '0)) begin
            src_nxt   = 1'b1;
            phead_nxt = (phead_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : phead_r + 1'b1;
            pcnt_nxt  = pcnt_r - 1'b1;
            state_nxt = S_EVQ;
          end else if (acnt_r != '0) begin
            src_nxt   = 1'b0;
            ahead_nxt = (ahead_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : ahead_r + 1'b1;
            acnt_nxt  = acnt_r - 1'b1;
            state_nxt = S_EVQ;
          end
        end
      end
      S_EVQ: begin
        vic_nxt   = victim;
        ent_raddr = victim;
        state_nxt = S_EVM;
      end
      S_EVM: begin
        ent_waddr = vic_r;
        if (ent_p && ent_refs != 2'd0) begin
          ent_we = 1'b1;
          if (ent_refs == 2'd1) begin
            bytes_nxt = bytes_sub(bytes_r, 32'(ent_len));
            tot_nxt   = tot_r - 1'b1;
            if (freed_r != CNT_MAX) begin
              freed_nxt = freed_r + 11'd1;
            end
          end else begin
            ent_wdata = {1'b1, ent_refs - 2'd1, ent_len};
          end
        end
        state_nxt = S_EVCHK;
      end
      S_TDEC: begin
        if (!ent_p) begin
          if (tot_r >= TOT_W'(SLOT_COUNT)) begin
            status_nxt = STAT_NO_SLOT;
            refout_nxt = 2'd0;
            state_nxt  = S_DONE;
          end else begin
            status_nxt   = STAT_OK;
            tot_nxt      = tot_r + 1'b1;
            cur_refs_nxt = 2'd0;
            oldlen_nxt   = '0;
            rweff_nxt    = 1'b1;
            state_nxt    = S_TAPPLY;
          end
        end else if (pr_r) begin
          status_nxt = STAT_PRE_HIT;
          refout_nxt = ent_refs;
          state_nxt  = S_DONE;
        end else begin
          status_nxt   = STAT_OK;
          cur_refs_nxt = ent_refs;
          oldlen_nxt   = ent_len;
          rweff_nxt    = rw_r;
          if (rw_r) begin
            bytes_nxt = bytes_sub(bytes_r, 32'(ent_len));
          end
          state_nxt = S_TAPPLY;
        end
      end
      S_TAPPLY: begin
        if (rweff_r) begin
          bytes_nxt = bytes_add(bytes_r, 32'(len_r));
        end
        if (do_push) begin
          if (pr_r) begin
            qp_we     = 1'b1;
            ptail_nxt = (ptail_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : ptail_r + 1'b1;
            pcnt_nxt  = pcnt_r + 1'b1;
          end else begin
            qa_we     = 1'b1;
            atail_nxt = (atail_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : atail_r + 1'b1;
            acnt_nxt  = acnt_r + 1'b1;
          end
        end
        ent_we     = 1'b1;
        ent_wdata  = {1'b1, refs_new, newlen};
        refout_nxt = refs_new;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_v_r || res_pop) begin
          out_v_nxt               = 1'b1;
          res_nxt.status          = status_r;
          res_nxt.was_present     = was_r;
          res_nxt.freed_count     = freed_r;
          res_nxt.entry_refcount  = refout_r;
          res_nxt.cached_count    = count_out;
          res_nxt.cached_bytes    = bytes_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, counters and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      tot_r   <= '0;
      bytes_r <= '0;
      ahead_r <= '0;
      atail_r <= '0;
      phead_r <= '0;
      ptail_r <= '0;
      acnt_r  <= '0;
      pcnt_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      tot_r   <= tot_nxt;
      bytes_r <= bytes_nxt;
      ahead_r <= ahead_nxt;
      atail_r <= atail_nxt;
      phead_r <= phead_nxt;
      ptail_r <= ptail_nxt;
      acnt_r  <= acnt_nxt;
      pcnt_r  <= pcnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Hold request payload and working values
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    len_r      <= len_nxt;
    rw_r       <= rw_nxt;
    pr_r       <= pr_nxt;
    vic_r      <= vic_nxt;
    src_r      <= src_nxt;
    was_r      <= was_nxt;
    freed_r    <= freed_nxt;
    status_r   <= status_nxt;
    refout_r   <= refout_nxt;
    cur_refs_r <= cur_refs_nxt;
    oldlen_r   <= oldlen_nxt;
    rweff_r    <= rweff_nxt;
    res_r      <= res_nxt;
  end

  // Entry store: present flag, reference count, length
  rfc_ram #(.WIDTH(EW), .DEPTH(NODE_COUNT)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // Access FIFO storage
  rfc_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_DEPTH)) u_access_ram (
    .clk   (clk),
    .we    (qa_we),
    .waddr (atail_r),
    .wdata (idx_r),
    .raddr (ahead_r),
    .rdata (qa_rdata)
  );

  // Preread FIFO storage
  rfc_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_DEPTH)) u_preread_ram (
    .clk   (clk),
    .we    (qp_we),
    .waddr (ptail_r),
    .wdata (idx_r),
    .raddr (phead_r),
    .rdata (qp_rdata)
  );

  assign clearing  = (state_r == S_CLEAR);
  assign res_valid = out_v_r;
  assign res       = res_r;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !req_pop)
    else $error("request taken during clearing pass");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (acnt_r <= QCW'(QUEUE_DEPTH)) && (pcnt_r <= QCW'(QUEUE_DEPTH)))
    else $error("FIFO count above depth");

  a_evm_after_evq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVQ) |=> (state_r == S_EVM))
    else $error("victim lookup skipped");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tot_r <= TOT_W'(SLOT_COUNT))
    else $error("entry total above slot count");

endmodule

// ----- rtl/refcount_fifo_cache_policy_unit.sv -----
// Reference-counted FIFO cache policy unit.
// Input channel: write a request (block index, value length, rewrite, preread)
// with push while full is low. Result channel: one result per request, shown
// while empty is low and taken with pop; results leave in request order.
// Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12
// (enable, max entries, max bytes, preread threshold); write only while idle.
// Path: the front end reduces the index (index times reciprocal, then quotient
// times node count) and queues the request; the back-end sequencer then reads
// the entry, pops FIFO entries for eviction while over either limit, and writes
// the touched entry. A disabled cache skips eviction and touch; a rejected or
// preread-hit request skips the write. The back end works on one request at a time.
// A four-deep request queue between front and back lets the input side keep
// taking requests while the back end works or the result waits.
// Reset: after rst_n the entry store is swept clean, one entry per cycle,
// with full held high; configuration writes still work.
// When the receiver does not pop, the result register holds its beat, the
// back end stops after its next request and full rises once the queue fills.
module refcount_fifo_cache_policy_unit import rfc_pkg::*; #(
  parameter int NODE_COUNT  = 65536,
  parameter int SLOT_COUNT  = 1024,
  parameter int QUEUE_DEPTH = 4096,
  parameter int LENGTH_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [INDEX_BITS-1:0]  in_block_index,
  input  logic [LENGTH_BITS-1:0] in_value_length,
  input  logic                   in_rewrite,
  input  logic                   in_preread,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             out_status,
  output logic                   out_was_present,
  output logic [10:0]            out_freed_count,
  output logic [1:0]             out_entry_refcount,
  output logic [10:0]            out_cached_count,
  output logic [30:0]            out_cached_bytes,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int IDX_W = $clog2(NODE_COUNT);

  rfc_cfg_t         cfg_r;
  logic             cfg_wr;
  logic [1:0]       reg_sel;
  logic             clearing;
  logic             req_valid;
  logic             req_pop;
  logic [IDX_W-1:0] req_idx;
  logic [LENGTH_BITS-1:0] req_len;
  logic             req_rewrite;
  logic             req_preread;
  logic             res_valid;
  rfc_result_t      res;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b1;
      cfg_r.max_entries <= 11'd1024;
      cfg_r.max_bytes   <= 30'd268435456;
      cfg_r.threshold   <= 12'd1024;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ENABLE:      cfg_r.enable      <= pwdata[0];
        REG_MAX_ENTRIES: cfg_r.max_entries <= pwdata[10:0];
        REG_MAX_BYTES:   cfg_r.max_bytes   <= pwdata[29:0];
        REG_THRESHOLD:   cfg_r.threshold   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (reg_sel)
      REG_ENABLE:      prdata = {31'd0, cfg_r.enable};
      REG_MAX_ENTRIES: prdata = {21'd0, cfg_r.max_entries};
      REG_MAX_BYTES:   prdata = {2'd0, cfg_r.max_bytes};
      REG_THRESHOLD:   prdata = {20'd0, cfg_r.threshold};
      default:         prdata = '0;
    endcase
  end

  rfc_front #(
    .NODE_COUNT  (NODE_COUNT),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .hold            (clearing),
    .in_push         (push),
    .in_full         (full),
    .in_block_index  (in_block_index),
    .in_value_length (in_value_length),
    .in_rewrite      (in_rewrite),
    .in_preread      (in_preread),
    .req_valid       (req_valid),
    .req_pop         (req_pop),
    .req_idx         (req_idx),
    .req_len         (req_len),
    .req_rewrite     (req_rewrite),
    .req_preread     (req_preread)
  );

  rfc_back #(
    .NODE_COUNT  (NODE_COUNT),
    .SLOT_COUNT  (SLOT_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .req_valid   (req_valid),
    .req_pop     (req_pop),
    .req_idx     (req_idx),
    .req_len     (req_len),
    .req_rewrite (req_rewrite),
    .req_preread (req_preread),
    .clearing    (clearing),
    .res_valid   (res_valid),
    .res         (res),
    .res_pop     (pop)
  );

  assign empty              = !res_valid;
  assign out_status         = res.status;
  assign out_was_present    = res.was_present;
  assign out_freed_count    = res.freed_count;
  assign out_entry_refcount = res.entry_refcount;
  assign out_cached_count   = res.cached_count;
  assign out_cached_bytes   = res.cached_bytes;

endmodule

// ----- tb/refcount_fifo_cache_policy_unit_test.sv -----
`timescale 1ns / 1ps

module refcount_fifo_cache_policy_unit_test;
  import rfc_pkg::*;

  localparam int NODES = 65536;
  localparam int SLOTS = 1024;
  localparam int QDEPTH = 4096;
  localparam int PEND_DEPTH = 64;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] in_block_index = '0;
  logic [19:0] in_value_length = '0;
  logic        in_rewrite = 1'b0;
  logic        in_preread = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_status;
  logic        out_was_present;
  logic [10:0] out_freed_count;
  logic [1:0]  out_entry_refcount;
  logic [10:0] out_cached_count;
  logic [30:0] out_cached_bytes;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  refcount_fifo_cache_policy_unit uut (.*);

  // Clock: period 8 ns
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the cache policy state
  rfc_cfg_t    cfg;
  bit          present [NODES];
  logic [1:0]  refs [NODES];
  logic [19:0] lengths [NODES];
  logic [15:0] acc_mem [QDEPTH];
  int unsigned acc_head = 0;
  int unsigned acc_size = 0;
  logic [15:0] pre_mem [QDEPTH];
  int unsigned pre_head = 0;
  int unsigned pre_size = 0;
  int unsigned entries;
  logic [30:0] bytes_held;

  // Expected result beats in request order
  rfc_result_t pend_mem [PEND_DEPTH];
  int unsigned pend_head = 0;
  int unsigned pend_size = 0;
  int          mismatches = 0;
  int          cycles = 0;

  // Evict, touch and queue one request; return the result it causes
  function automatic rfc_result_t cache_touch(logic [15:0] idx, logic [19:0] len,
                                              bit rewrite, bit preread);
    rfc_result_t r;
    logic [1:0]  st;
    int unsigned freed;
    logic [15:0] v;
    st = STAT_OK;
    freed = 0;
    r.was_present = present[idx];
    if (!cfg.enable) begin
      st = STAT_DISABLED;
    end else begin
      // Evict while over either limit
      while (entries >= cfg.max_entries || bytes_held >= {1'b0, cfg.max_bytes}) begin
        if (pre_size > cfg.threshold || (acc_size == 0 && pre_size != 0)) begin
          v = pre_mem[pre_head];
          pre_head = (pre_head + 1) % QDEPTH;
          pre_size--;
        end else if (acc_size != 0) begin
          v = acc_mem[acc_head];
          acc_head = (acc_head + 1) % QDEPTH;
          acc_size--;
        end else begin
          break;
        end
        if (present[v] && refs[v] != 0) begin
          refs[v]--;
          if (refs[v] == 0) begin
            bytes_held = bytes_sub(bytes_held, {12'd0, lengths[v]});
            lengths[v] = '0;
            present[v] = 1'b0;
            entries--;
            if (freed < 2047) freed++;
          end
        end
      end
      if (!present[idx]) begin
        if (entries >= SLOTS) begin
          st = STAT_NO_SLOT;
        end else begin
          present[idx] = 1'b1;
          refs[idx] = '0;
          lengths[idx] = '0;
          entries++;
          rewrite = 1'b1;
        end
      end else if (preread) begin
        st = STAT_PRE_HIT;
      end
      if (st == STAT_OK) begin
        if (rewrite) begin
          bytes_held = bytes_sub(bytes_held, {12'd0, lengths[idx]});
          lengths[idx] = len;
          bytes_held = bytes_add(bytes_held, {12'd0, len});
        end
        if (refs[idx] < REF_LIMIT) begin
          if (preread && pre_size < QDEPTH) begin
            pre_mem[(pre_head + pre_size) % QDEPTH] = idx;
            pre_size++;
            refs[idx]++;
          end else if (!preread && acc_size < QDEPTH) begin
            acc_mem[(acc_head + acc_size) % QDEPTH] = idx;
            acc_size++;
            refs[idx]++;
          end
        end
      end
    end
    r.status = st;
    r.freed_count = 11'(freed);
    r.entry_refcount = present[idx] ? refs[idx] : 2'd0;
    r.cached_count = (entries > 2047) ? CNT_MAX : 11'(entries);
    r.cached_bytes = bytes_held;
    return r;
  endfunction

  // Write one register through the configuration port
  task automatic reg_write(logic [1:0] which, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (which)
      REG_ENABLE:      cfg.enable = value[0];
      REG_MAX_ENTRIES: cfg.max_entries = value[10:0];
      REG_MAX_BYTES:   cfg.max_bytes = value[29:0];
      REG_THRESHOLD:   cfg.threshold = value[11:0];
      default: ;
    endcase
  endtask

  // Write all four registers
  task automatic set_policy(bit en, logic [10:0] me, logic [29:0] mb, logic [11:0] th);
    reg_write(REG_ENABLE, {31'd0, en});
    reg_write(REG_MAX_ENTRIES, {21'd0, me});
    reg_write(REG_MAX_BYTES, {2'd0, mb});
    reg_write(REG_THRESHOLD, {20'd0, th});
  endtask

  // Drop push, drain expectations, then let the back end settle
  task automatic wait_idle();
    push <= 1'b0;
    while (pend_size != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Send one request beat; typed is the directed expectation, if any
  task automatic send_beat(logic [15:0] idx, logic [19:0] len, bit rw, bit pr,
                           bit typed, rfc_result_t known);
    rfc_result_t e;
    int wait_n;
    wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (wait_n != 0) begin
      push <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    push <= 1'b1;
    in_block_index <= idx;
    in_value_length <= len;
    in_rewrite <= rw;
    in_preread <= pr;
    do @(posedge clk); while (full);
    e = cache_touch(idx, len, rw, pr);
    if (typed && e !== known)
      $display("directed row disagrees with shadow: idx %0d", idx);
    pend_mem[(pend_head + pend_size) % PEND_DEPTH] = typed ? known : e;
    pend_size++;
  endtask

  // Result side: random stalls, compare every popped beat
  initial begin : result_side
    rfc_result_t got;
    rfc_result_t exp_r;
    int wait_n;
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (wait_n != 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got = '{out_status, out_was_present, out_freed_count, out_entry_refcount,
              out_cached_count, out_cached_bytes};
      if (pend_size == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp_r = pend_mem[pend_head];
        pend_head = (pend_head + 1) % PEND_DEPTH;
        pend_size--;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  typedef struct {
    logic [15:0] idx;
    logic [19:0] len;
    bit          rw;
    bit          pr;
    bit          typed;
    rfc_result_t known;
  } row_t;

  row_t rows [10] = '{
    '{16'd0,     20'd0,       1'b0, 1'b0, 1'b1, '{STAT_OK, 1'b0, 11'd0, 2'd1, 11'd1, 31'd0}},
    '{16'd65535, 20'hFFFFF,   1'b1, 1'b0, 1'b1,
      '{STAT_OK, 1'b0, 11'd0, 2'd1, 11'd2, 31'hFFFFF}},
    '{16'd65535, 20'd5,       1'b0, 1'b1, 1'b1,
      '{STAT_PRE_HIT, 1'b1, 11'd0, 2'd1, 11'd2, 31'hFFFFF}},
    '{16'd0,     20'd100,     1'b1, 1'b0, 1'b0, '0},
    '{16'd0,     20'd7,       1'b0, 1'b0, 1'b0, '0},
    '{16'd0,     20'd7,       1'b0, 1'b0, 1'b0, '0},
    '{16'd12,    20'd300,     1'b0, 1'b1, 1'b0, '0},
    '{16'hAAAA,  20'h55555,   1'b1, 1'b1, 1'b0, '0},
    '{16'h5555,  20'hAAAAA,   1'b0, 1'b0, 1'b0, '0},
    '{16'd65535, 20'd9,       1'b1, 1'b0, 1'b0, '0}
  };

  initial begin : request_side
    rfc_result_t none;
    int mode;
    logic [15:0] idx;
    logic [15:0] base;
    none = '0;
    cfg = '{1'b1, 11'd1024, 30'd268435456, 12'd1024};
    for (int i = 0; i < NODES; i++) begin
      present[i] = 1'b0;
      refs[i] = '0;
      lengths[i] = '0;
    end
    entries = 0;
    bytes_held = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows at reset settings
    foreach (rows[i]) send_beat(rows[i].idx, rows[i].len, rows[i].rw, rows[i].pr,
                                rows[i].typed, rows[i].known);
    wait_idle();

    // Cache disabled: everything rejected
    set_policy(1'b0, 11'd1024, 30'd268435456, 12'd1024);
    send_beat(16'd3, 20'd1, 1'b1, 1'b0, 1'b0, none);
    send_beat(16'd0, 20'd1, 1'b0, 1'b1, 1'b0, none);
    wait_idle();

    // Tight limits: one entry, zero bytes, zero threshold
    set_policy(1'b1, 11'd1, 30'd0, 12'd0);
    for (int i = 0; i < 6; i++)
      send_beat(16'(i * 7), 20'(i), 1'b0, i[0], 1'b0, none);
    wait_idle();

    // Random phases under several policies
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_policy(1'b1, 11'd1024, 30'h3FFFFFFF, 12'd4095);
        1: set_policy(1'b1, 11'd2047, 30'h3FFFFFFF, 12'd2);
        2: set_policy(1'b1, 11'd8, 30'd4000000, 12'd1);
        3: set_policy(1'b1, 11'd1, 30'd268435456, 12'd0);
        4: set_policy(1'b0, 11'd16, 30'd1000, 12'd3);
        5: set_policy(1'b1, 11'd32, 30'd20000000, 12'd5);
        6: set_policy(1'b1, 11'(1 + $urandom_range(0, 60)), 30'($urandom),
                      12'($urandom_range(0, 20)));
        default: set_policy(1'b1, 11'd1024, 30'd0, 12'd4095);
      endcase
      base = 16'($urandom);
      for (int n = 0; n < 115; n++) begin
        mode = $urandom_range(0, 9);
        // Mostly reuse a small working set so hits and refcounts build up
        if (mode < 7) idx = base + 16'($urandom_range(0, 40));
        else idx = 16'($urandom);
        send_beat(idx, (mode == 9) ? 20'hFFFFF : 20'($urandom),
                  $urandom_range(0, 1), $urandom_range(0, 2) == 0, 1'b0, none);
      end
      wait_idle();
    end

    if (mismatches == 0 && pend_size == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rfc_pkg.sv
rtl/rfc_ram.sv
rtl/rfc_front.sv
rtl/rfc_back.sv
rtl/refcount_fifo_cache_policy_unit.sv
tb/refcount_fifo_cache_policy_unit_test.sv
